[hdl/lkvc_pkg.sv]
package lkvc_pkg;

    // field widths and defaults
    localparam int          MAX_ENTRIES_DEF = 16;
    localparam int          DATA_W          = 32;
    localparam int          CAP_W           = 5;
    localparam logic [4:0]  CAP_RESET       = 5'd16;
    localparam logic [31:0] MISS_VALUE      = 32'hFFFF_FFFF;

    // request kinds
    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_PUT = 1'b1
    } req_kind_t;

    // one request as handed to the entry store
    typedef struct packed {
        req_kind_t         kind;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } lkvc_req_t;

    // one result as returned by the entry store
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
        logic [DATA_W-1:0] evicted_key;
    } lkvc_rsp_t;

endpackage

[hdl/lkvc_store.sv]
module lkvc_store #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req_en,
    input  lkvc_pkg::lkvc_req_t         req,
    input  logic [lkvc_pkg::CAP_W-1:0]  capacity,
    output lkvc_pkg::lkvc_rsp_t         rsp
);

    localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

    // entry state: one lane per entry
    logic [MAX_ENTRIES-1:0]        valid_reg, valid_next;
    logic [RANK_W-1:0]             rank_reg  [MAX_ENTRIES];
    logic [RANK_W-1:0]             rank_next [MAX_ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0]   key_reg   [MAX_ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0]   value_reg [MAX_ENTRIES];
    logic [CNT_W-1:0]              live_count_reg, live_count_next;

    // lookup results
    logic [MAX_ENTRIES-1:0]        match, oldest, free_oh;
    logic [RANK_W-1:0]             found_rank, last_rank;
    logic [lkvc_pkg::DATA_W-1:0]   found_value, oldest_key;
    logic [CNT_W-1:0]              live_dec;
    logic [CMP_W-1:0]              cap_ext, cap_eff, live_ext;
    logic                          is_put, hit, full;

    // update control
    logic [MAX_ENTRIES-1:0]        touch_oh, write_oh, shrink_oh;
    logic [RANK_W-1:0]             touch_rank;
    logic [RANK_W-1:0]             rank_tmp [MAX_ENTRIES];
    logic                          inc_all, shrink;
    logic [lkvc_pkg::DATA_W-1:0]   shrink_key;

    // parallel key compare and oldest search
    assign live_dec  = live_count_reg - CNT_W'(1);
    assign last_rank = live_dec[RANK_W-1:0];
    assign free_oh   = ~valid_reg & (valid_reg + MAX_ENTRIES'(1));

    always_comb begin
        match       = '0;
        oldest      = '0;
        found_rank  = '0;
        found_value = '0;
        oldest_key  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i]  = valid_reg[i] && (key_reg[i] == req.key);
            oldest[i] = valid_reg[i] && (live_count_reg != '0) && (rank_reg[i] == last_rank);
            found_rank  = found_rank  | ({RANK_W{match[i]}} & rank_reg[i]);
            found_value = found_value | ({lkvc_pkg::DATA_W{match[i]}} & value_reg[i]);
            oldest_key  = oldest_key  | ({lkvc_pkg::DATA_W{oldest[i]}} & key_reg[i]);
        end
    end

    // effective capacity: zero acts as one, clipped to the entry count
    always_comb begin
        cap_ext  = CMP_W'(capacity);
        live_ext = CMP_W'(live_count_reg);
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
            cap_eff = CMP_W'(MAX_ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
    end

    assign is_put = (req.kind == lkvc_pkg::REQ_PUT);
    assign hit    = |match;
    assign full   = (live_ext >= cap_eff) || (live_ext >= CMP_W'(MAX_ENTRIES));

    // choose the entry made most recent and the entry written
    always_comb begin
        touch_oh        = '0;
        write_oh        = '0;
        touch_rank      = '0;
        inc_all         = 1'b0;
        valid_next      = valid_reg;
        live_count_next = live_count_reg;
        rsp.hit         = hit;
        rsp.read_value  = lkvc_pkg::MISS_VALUE;
        rsp.evicted     = 1'b0;
        rsp.evicted_key = '0;
        priority if (hit) begin
            touch_oh   = match;
            touch_rank = found_rank;
            if (is_put) begin
                write_oh = match;
            end else begin
                rsp.read_value = found_value;
            end
        end else if (is_put && full) begin
            touch_oh        = oldest;
            touch_rank      = last_rank;
            write_oh        = oldest;
            rsp.evicted     = |oldest;
            rsp.evicted_key = oldest_key;
        end else if (is_put) begin
            touch_oh        = free_oh;
            write_oh        = free_oh;
            inc_all         = 1'b1;
            valid_next      = valid_reg | free_oh;
            live_count_next = live_count_reg + CNT_W'(|free_oh);
        end else begin
            touch_oh = '0;
        end

        // rank update: more recent entries age by one
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (touch_oh[i]) begin
                rank_tmp[i] = '0;
            end else if (valid_reg[i] && (inc_all || rank_reg[i] < touch_rank) && (|touch_oh)) begin
                rank_tmp[i] = rank_reg[i] + RANK_W'(1);
            end else begin
                rank_tmp[i] = rank_reg[i];
            end
        end

        // put hit above capacity drops the oldest entry after the touch
        shrink_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            shrink_oh[i] = valid_reg[i] && !match[i] && (rank_tmp[i] == last_rank);
            shrink_key   = shrink_key | ({lkvc_pkg::DATA_W{shrink_oh[i]}} & key_reg[i]);
        end
        shrink = hit && is_put && (live_ext > cap_eff) && (|shrink_oh);
        if (shrink) begin
            valid_next      = valid_reg & ~shrink_oh;
            live_count_next = live_dec;
            rsp.evicted     = 1'b1;
            rsp.evicted_key = shrink_key;
        end

        for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_next[i] = rank_tmp[i];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            live_count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else if (req_en) begin
            valid_reg      <= valid_next;
            live_count_reg <= live_count_next;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // entry payload
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (req_en && write_oh[i]) begin
                key_reg[i]   <= req.key;
                value_reg[i] <= req.value;
            end
        end
    end

    // live count tracks the valid entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(live_count_reg))
        else $error("live count does not match valid entries");

    // keys stay unique, so at most one entry matches
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match))
        else $error("duplicate key in store");

    // the least recent rank belongs to exactly one entry when not empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (live_count_reg != '0) |-> $onehot(oldest))
        else $error("recency ranks are inconsistent");

    // only puts evict, and the live count never exceeds the entry count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (req_en && rsp.evicted) |-> is_put)
        else $error("eviction on a get");

    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(live_count_reg) <= MAX_ENTRIES)
        else $error("live count overflow");

endmodule

[hdl/lru_key_value_cache.sv]
// path: an accepted item goes into the input register, and its result goes into the result
//   register when the stage advances
// throughput: one item per cycle while the result slot is free or drains; key compare
//   and recency rank update over all entries are combinational between the registers
// reset (aresetn low, synchronous): all entries invalid, ranks and live count zero,
//   capacity 16, both channels empty; no clearing pass is needed
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]           cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_req_type,
    input  logic signed [lkvc_pkg::DATA_W-1:0]   s_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0]   s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0]   m_read_value,
    output logic                                 m_evicted,
    output logic signed [lkvc_pkg::DATA_W-1:0]   m_evicted_key
);

    logic [lkvc_pkg::CAP_W-1:0]    cap_reg;
    logic                          in_valid_reg;
    lkvc_pkg::lkvc_req_t           in_reg;
    logic                          out_valid_reg;
    lkvc_pkg::lkvc_rsp_t           out_reg;
    lkvc_pkg::lkvc_rsp_t           rsp;
    logic                          advance;

    // handshake: stage advances when the result slot is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lkvc_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.kind  <= lkvc_pkg::req_kind_t'(s_req_type);
            in_reg.key   <= s_key;
            in_reg.value <= s_value;
        end
    end

    // entry store with lookup and update
    lkvc_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_en   (advance),
        .req      (in_reg),
        .capacity (cap_reg),
        .rsp      (rsp)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= rsp;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_hit         = out_reg.hit;
    assign m_read_value  = out_reg.read_value;
    assign m_evicted     = out_reg.evicted;
    assign m_evicted_key = out_reg.evicted_key;

endmodule

[tb/sv/lru_key_value_cache_tb.sv]
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

    localparam int          ENTRIES     = lkvc_pkg::MAX_ENTRIES_DEF;
    localparam int          RSP_LATENCY = 2;
    localparam int          STALL_LIMIT = 2000;
    localparam int          SEG_ITEMS   = 340;
    localparam logic [31:0] KEY_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] KEY_MIN     = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    // directed table rows: a request or a capacity write
    typedef enum logic {
        DIR_REQ,
        DIR_CFG
    } dir_op_t;

    typedef struct {
        dir_op_t              op;
        lkvc_pkg::req_kind_t  kind;
        logic [31:0]          key;
        logic [31:0]          value;
        logic [4:0]           cap;
        bit                   typed;
        lkvc_pkg::lkvc_rsp_t  want;
    } dir_row_t;

    logic                               aclk        = 1'b0;
    logic                               aresetn     = 1'b0;
    logic                               cfg_wr_en   = 1'b0;
    logic [lkvc_pkg::CAP_W-1:0]         cfg_wr_data = '0;
    logic                               s_valid     = 1'b0;
    logic                               s_ready;
    logic                               s_req_type  = 1'b0;
    logic [lkvc_pkg::DATA_W-1:0]        s_key       = '0;
    logic [lkvc_pkg::DATA_W-1:0]        s_value     = '0;
    logic                               m_valid;
    logic                               m_ready     = 1'b0;
    logic                               m_hit;
    logic signed [lkvc_pkg::DATA_W-1:0] m_read_value;
    logic                               m_evicted;
    logic signed [lkvc_pkg::DATA_W-1:0] m_evicted_key;

    // shadow of the entry store
    bit          slot_valid [ENTRIES];
    logic [31:0] slot_key   [ENTRIES];
    logic [31:0] slot_value [ENTRIES];
    int          slot_rank  [ENTRIES];
    int          slot_count;
    logic [4:0]  cap_setting;

    lkvc_pkg::lkvc_rsp_t pending_rsp_q [$];
    dir_row_t            dir_rows [$];
    logic [31:0]         key_pool [24];
    int                  mismatch_count = 0;
    int                  stall_cycles   = 0;
    int                  send_idle_pct  = 24;
    int                  recv_idle_pct  = 62;

    lru_key_value_cache uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_key         (s_key),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_read_value  (m_read_value),
        .m_evicted     (m_evicted),
        .m_evicted_key (m_evicted_key)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int effective_cap(logic [4:0] cap);
        if (cap == 0) return 1;
        if (cap > ENTRIES) return ENTRIES;
        return int'(cap);
    endfunction

    // make slot s most recent, entries newer than it age by one
    function automatic void promote(int s);
        int r;
        r = slot_rank[s];
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    // least recently used live slot, -1 when empty
    function automatic int lru_slot();
        int s;
        s = -1;
        if (slot_count == 0) return -1;
        for (int i = 0; i < ENTRIES; i++)
            if (s < 0 && slot_valid[i] && slot_rank[i] == slot_count - 1) s = i;
        return s;
    endfunction

    // expected result of one request, updates the shadow store
    function automatic lkvc_pkg::lkvc_rsp_t lru_lookup(lkvc_pkg::req_kind_t kind,
                                                       logic [31:0] key,
                                                       logic [31:0] value);
        lkvc_pkg::lkvc_rsp_t rsp;
        int                  eff;
        int                  hit_slot;
        int                  s;
        rsp.hit         = 1'b0;
        rsp.read_value  = lkvc_pkg::MISS_VALUE;
        rsp.evicted     = 1'b0;
        rsp.evicted_key = '0;
        eff             = effective_cap(cap_setting);
        hit_slot        = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (hit_slot < 0 && slot_valid[i] && slot_key[i] == key) hit_slot = i;

        if (hit_slot >= 0) begin
            rsp.hit = 1'b1;
            if (kind == lkvc_pkg::REQ_PUT) slot_value[hit_slot] = value;
            else rsp.read_value = slot_value[hit_slot];
            promote(hit_slot);
            // shrink by one after the capacity was lowered
            if (kind == lkvc_pkg::REQ_PUT && slot_count > eff) begin
                s = lru_slot();
                if (s >= 0 && s != hit_slot) begin
                    rsp.evicted     = 1'b1;
                    rsp.evicted_key = slot_key[s];
                    slot_valid[s]   = 1'b0;
                    slot_count--;
                end
            end
        end else if (kind == lkvc_pkg::REQ_PUT) begin
            if (slot_count >= eff) begin
                // replace the oldest entry in place
                s = lru_slot();
                if (s >= 0) begin
                    rsp.evicted     = 1'b1;
                    rsp.evicted_key = slot_key[s];
                    promote(s);
                    slot_key[s]   = key;
                    slot_value[s] = value;
                end
            end else begin
                s = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (s < 0 && !slot_valid[i]) s = i;
                if (s >= 0) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot_valid[i]) slot_rank[i]++;
                    slot_valid[s] = 1'b1;
                    slot_key[s]   = key;
                    slot_value[s] = value;
                    slot_rank[s]  = 0;
                    slot_count++;
                end
            end
        end
        return rsp;
    endfunction

    // directed table builders
    function automatic void add_req(lkvc_pkg::req_kind_t kind, logic [31:0] key,
                                    logic [31:0] value);
        dir_row_t row;
        row.op    = DIR_REQ;
        row.kind  = kind;
        row.key   = key;
        row.value = value;
        row.cap   = '0;
        row.typed = 1'b0;
        row.want  = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_chk(lkvc_pkg::req_kind_t kind, logic [31:0] key,
                                    logic [31:0] value, logic hit, logic [31:0] rd,
                                    logic ev, logic [31:0] evk);
        dir_row_t row;
        row.op               = DIR_REQ;
        row.kind             = kind;
        row.key              = key;
        row.value            = value;
        row.cap              = '0;
        row.typed            = 1'b1;
        row.want.hit         = hit;
        row.want.read_value  = rd;
        row.want.evicted     = ev;
        row.want.evicted_key = evk;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [4:0] cap);
        dir_row_t row;
        row.op    = DIR_CFG;
        row.kind  = lkvc_pkg::REQ_GET;
        row.key   = '0;
        row.value = '0;
        row.cap   = cap;
        row.typed = 1'b0;
        row.want  = '0;
        dir_rows.push_back(row);
    endfunction

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // present one item, hold it until accepted, then queue its expected result
    task automatic send_req(input lkvc_pkg::req_kind_t kind, input logic [31:0] key,
                            input logic [31:0] value, input bit typed,
                            input lkvc_pkg::lkvc_rsp_t want);
        lkvc_pkg::lkvc_rsp_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= kind;
        s_key      <= key;
        s_value    <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = lru_lookup(kind, key, value);
        pending_rsp_q.push_back(typed ? want : predicted);
    endtask

    // capacity write once every result is out
    task automatic write_capacity(input logic [4:0] cap);
        s_valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cap_setting = cap;
    endtask

    // random requests over a small key pool so hits and evictions are frequent
    task automatic run_segment(input logic [4:0] cap);
        int                  pool_n;
        lkvc_pkg::req_kind_t kind;
        logic [31:0]         key;
        logic [31:0]         value;
        write_capacity(cap);
        pool_n = effective_cap(cap) + 4;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        for (int n = 0; n < SEG_ITEMS; n++) begin
            kind = $urandom_range(0, 1) ? lkvc_pkg::REQ_PUT : lkvc_pkg::REQ_GET;
            key  = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, pool_n - 1)]
                                                : $urandom;
            case ($urandom_range(0, 19))
                0:       value = '0;
                1:       value = KEY_MAX;
                2:       value = KEY_MIN;
                3:       value = ALL_ONES;
                default: value = $urandom;
            endcase
            send_req(kind, key, value, 1'b0, '0);
        end
    endtask

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge aclk) begin
        lkvc_pkg::lkvc_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp_q.size() == 0) begin
                report($sformatf("result with nothing expected (hit %b value %h)",
                                 m_hit, m_read_value));
            end else begin
                want = pending_rsp_q.pop_front();
                if (m_hit !== want.hit)
                    report($sformatf("hit got %b want %b", m_hit, want.hit));
                if (m_read_value !== want.read_value)
                    report($sformatf("read_value got %h want %h",
                                     m_read_value, want.read_value));
                if (m_evicted !== want.evicted)
                    report($sformatf("evicted got %b want %b", m_evicted, want.evicted));
                if (m_evicted_key !== want.evicted_key)
                    report($sformatf("evicted_key got %h want %h",
                                     m_evicted_key, want.evicted_key));
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        // shadow store after reset
        foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_rank[i]  = 0;
        end
        slot_count  = 0;
        cap_setting = lkvc_pkg::CAP_RESET;

        // empty store, extreme keys and values
        add_chk(lkvc_pkg::REQ_GET, 32'd0, 32'd0, 1'b0, lkvc_pkg::MISS_VALUE, 1'b0, 32'd0);
        add_chk(lkvc_pkg::REQ_PUT, KEY_MAX, KEY_MIN, 1'b0, lkvc_pkg::MISS_VALUE, 1'b0, 32'd0);
        add_chk(lkvc_pkg::REQ_PUT, KEY_MIN, KEY_MAX, 1'b0, lkvc_pkg::MISS_VALUE, 1'b0, 32'd0);
        add_chk(lkvc_pkg::REQ_GET, KEY_MAX, 32'd0, 1'b1, KEY_MIN, 1'b0, 32'd0);
        add_chk(lkvc_pkg::REQ_PUT, KEY_MIN, ALL_ONES, 1'b1, lkvc_pkg::MISS_VALUE, 1'b0, 32'd0);
        add_chk(lkvc_pkg::REQ_GET, KEY_MIN, 32'd0, 1'b1, ALL_ONES, 1'b0, 32'd0);
        // capacity lowered below the live count: gets keep, puts shrink
        add_cfg(5'd1);
        add_chk(lkvc_pkg::REQ_GET, KEY_MAX, 32'd0, 1'b1, KEY_MIN, 1'b0, 32'd0);
        add_chk(lkvc_pkg::REQ_PUT, KEY_MAX, 32'd1, 1'b1, lkvc_pkg::MISS_VALUE, 1'b1, KEY_MIN);
        add_chk(lkvc_pkg::REQ_PUT, 32'd5, 32'd5, 1'b0, lkvc_pkg::MISS_VALUE, 1'b1, KEY_MAX);
        add_chk(lkvc_pkg::REQ_GET, KEY_MAX, 32'd0, 1'b0, lkvc_pkg::MISS_VALUE, 1'b0, 32'd0);
        // zero capacity acts as one
        add_cfg(5'd0);
        add_chk(lkvc_pkg::REQ_PUT, 32'd6, 32'd6, 1'b0, lkvc_pkg::MISS_VALUE, 1'b1, 32'd5);
        add_chk(lkvc_pkg::REQ_GET, 32'd6, 32'd0, 1'b1, 32'd6, 1'b0, 32'd0);
        // oversized capacity clamps to the entry count
        add_cfg(5'd31);
        add_req(lkvc_pkg::REQ_PUT, 32'd0, 32'd0);
        add_req(lkvc_pkg::REQ_PUT, ALL_ONES, ALL_ONES);
        add_req(lkvc_pkg::REQ_GET, 32'd0, ALL_ONES);
        add_req(lkvc_pkg::REQ_PUT, 32'd0, 32'h5A5A_A5A5);
        add_req(lkvc_pkg::REQ_GET, ALL_ONES, 32'd0);
        add_chk(lkvc_pkg::REQ_GET, 32'h0000_1234, 32'd0, 1'b0, lkvc_pkg::MISS_VALUE, 1'b0,
                32'd0);
        add_cfg(5'd2);
        add_req(lkvc_pkg::REQ_GET, 32'd6, 32'd0);
        add_req(lkvc_pkg::REQ_PUT, 32'd0, 32'd7);
        add_req(lkvc_pkg::REQ_PUT, 32'd0, 32'd8);
        add_req(lkvc_pkg::REQ_PUT, 32'd9, 32'd9);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == DIR_CFG) begin
                write_capacity(dir_rows[i].cap);
            end else begin
                send_req(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].value,
                         dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // random traffic: receiver idles more, then sender, then no idling
        run_segment(5'd16);
        run_segment(5'd3);
        send_idle_pct = 62;
        recv_idle_pct = 24;
        run_segment(5'd1);
        run_segment(5'd8);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_segment(5'd31);
        run_segment(5'($urandom_range(0, 31)));

        // drain
        s_valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge aclk);
        repeat (RSP_LATENCY + 2) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
